[hdl/tpp_pkg.sv]
// Package for the touch packet parser: parse phases, configuration
// register indexes, reset values, the shared configuration struct and
// the result struct. No dependencies.
package tpp_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CellW   = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESS_SYNC   = 2'd0,
    CFG_RELEASE_SYNC = 2'd1,
    CFG_FILTER_EN    = 2'd2
  } cfg_idx_t;

  localparam logic [ByteW-1:0] PressSyncRst   = 8'd129;
  localparam logic [ByteW-1:0] ReleaseSyncRst = 8'd128;

  // Parse phase: waiting for a sync byte, then the four data bytes.
  typedef enum logic [2:0] {
    PH_SYNC = 3'd0,
    PH_X_LO = 3'd1,
    PH_X_HI = 3'd2,
    PH_Y_LO = 3'd3,
    PH_Y_HI = 3'd4
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] press_hdr;
    logic [ByteW-1:0] release_hdr;
    logic             filter_en;
  } cfg_t;

  typedef struct packed {
    logic [CellW-1:0] cell_x;
    logic [CellW-1:0] cell_y;
    logic             pressed_out;
    logic             packet_done;
    logic             packet_is_release;
  } result_t;

endpackage

[hdl/tpp_if.sv]
// Valid/ready channel interfaces of the touch packet parser: input bytes,
// results and configuration writes. Depends on tpp_pkg.
interface tpp_in_if import tpp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  logic             clear_pressed;

  modport source (output valid, rx_byte, clear_pressed, input ready);
  modport sink   (input valid, rx_byte, clear_pressed, output ready);
endinterface

interface tpp_out_if import tpp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CellW-1:0] cell_x;
  logic [CellW-1:0] cell_y;
  logic             pressed_out;
  logic             packet_done;
  logic             packet_is_release;

  modport source (output valid, cell_x, cell_y, pressed_out, packet_done,
                  packet_is_release, input ready);
  modport sink   (input valid, cell_x, cell_y, pressed_out, packet_done,
                  packet_is_release, output ready);
endinterface

interface tpp_cfg_if import tpp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/touch_packet_parser.sv]
// Touch packet parser, top level. A byte that is taken passes through the
// input register and then the result register, from which its result is
// transferred out. Throughput: one byte per cycle, set by the single-pass
// phase logic; a held result stalls the input only once both registers
// fill. Reset (rst_n, synchronous, active low) returns to the sync search,
// clears the pressed flag and touch cell, and loads sync bytes 129/128 with
// the filter off.
module touch_packet_parser
  import tpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tpp_in_if.sink    in_ch,
  tpp_out_if.source out_ch,
  tpp_cfg_if.sink   cfg_ch
);

  cfg_t cfg;

  // The configuration bank always accepts a write; the index selects the
  // press sync byte, the release sync byte or the filter enable, and an index
  // beyond those is taken and dropped.
  tpp_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // The parser registers each incoming byte, runs one step of the phase
  // machine on it and places the result in an output register. Because the
  // input register and the result register are separate, a new byte is
  // taken while a finished result still waits for its transfer.
  tpp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

[hdl/tpp_cfg.sv]
// Configuration register bank of the touch packet parser.
// Depends on tpp_pkg and tpp_cfg_if.
module tpp_cfg
  import tpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tpp_cfg_if.sink   cfg_ch,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PRESS_SYNC:   cfg_nxt.press_hdr   = cfg_ch.data;
        CFG_RELEASE_SYNC: cfg_nxt.release_hdr = cfg_ch.data;
        CFG_FILTER_EN:    cfg_nxt.filter_en   = cfg_ch.data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_hdr   <= PressSyncRst;
      cfg_r.release_hdr <= ReleaseSyncRst;
      cfg_r.filter_en   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hdl/tpp_parser.sv]
// Parser datapath of the touch packet parser: input register, phase state
// machine with coordinate and cell state, and the result register.
// Depends on tpp_pkg, tpp_in_if and tpp_out_if.
module tpp_parser
  import tpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  tpp_in_if.sink    in_ch,
  tpp_out_if.source out_ch
);

  // Input register.
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_clr_r;

  // Parser state. Only X bits 11..9 are ever latched, so only those are kept;
  // Y bits 11..9 come straight from the final byte.
  phase_t           phase_r, phase_nxt;
  logic             release_r, release_nxt;
  logic [CellW-1:0] x_top_r, x_top_nxt;
  logic [CellW-1:0] cell_x_r, cell_x_nxt;
  logic [CellW-1:0] cell_y_r, cell_y_nxt;
  logic             pressed_r, pressed_nxt;
  logic             done;

  // Result register.
  logic             out_valid_r;
  result_t          res_r;

  logic advance;
  logic proc;
  logic in_ready;
  logic pressed_clr;

  assign advance  = !out_valid_r || out_ch.ready;
  assign proc     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_ch.ready = in_ready;

  assign pressed_clr = pressed_r && !s1_clr_r;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (proc) begin
      unique case (phase_r)
        PH_SYNC: begin
          if (s1_byte_r == cfg.release_hdr || s1_byte_r == cfg.press_hdr) begin
            phase_nxt = PH_X_LO;
          end
        end
        PH_X_LO: phase_nxt = PH_X_HI;
        PH_X_HI: phase_nxt = PH_Y_LO;
        PH_Y_LO: phase_nxt = PH_Y_HI;
        PH_Y_HI: phase_nxt = PH_SYNC;
        default: phase_nxt = PH_SYNC;
      endcase
    end
  end

  // Data state and result fields.
  always_comb begin
    release_nxt = release_r;
    x_top_nxt   = x_top_r;
    cell_x_nxt  = cell_x_r;
    cell_y_nxt  = cell_y_r;
    pressed_nxt = pressed_r;
    done        = 1'b0;
    if (proc) begin
      pressed_nxt = pressed_clr;
      unique case (phase_r)
        PH_SYNC: begin
          if (s1_byte_r == cfg.release_hdr) begin
            release_nxt = 1'b1;
          end else if (s1_byte_r == cfg.press_hdr) begin
            release_nxt = 1'b0;
          end
        end
        PH_X_HI: x_top_nxt = s1_byte_r[4:2];
        PH_Y_HI: begin
          done = 1'b1;
          if (release_r) begin
            pressed_nxt = 1'b1;
          end else if (!pressed_clr && !cfg.filter_en) begin
            cell_x_nxt = x_top_r;
            cell_y_nxt = s1_byte_r[4:2];
          end
        end
        default: done = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SYNC;
      release_r   <= 1'b0;
      x_top_r     <= '0;
      cell_x_r    <= '0;
      cell_y_r    <= '0;
      pressed_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      phase_r   <= phase_nxt;
      release_r <= release_nxt;
      x_top_r   <= x_top_nxt;
      cell_x_r  <= cell_x_nxt;
      cell_y_r  <= cell_y_nxt;
      pressed_r <= pressed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_clr_r  <= in_ch.clear_pressed;
    end
    if (proc) begin
      res_r.cell_x            <= cell_x_nxt;
      res_r.cell_y            <= cell_y_nxt;
      res_r.pressed_out       <= pressed_nxt;
      res_r.packet_done       <= done;
      res_r.packet_is_release <= release_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.cell_x            = res_r.cell_x;
  assign out_ch.cell_y            = res_r.cell_y;
  assign out_ch.pressed_out       = res_r.pressed_out;
  assign out_ch.packet_done       = res_r.packet_done;
  assign out_ch.packet_is_release = res_r.packet_is_release;

  // A finished packet always returns the parser to the sync search.
  a_end_to_sync: assert property (@(posedge clk) disable iff (!rst_n)
    proc && phase_r == PH_Y_HI |=> phase_r == PH_SYNC)
    else $error("parser did not return to sync after a packet");

  // A completed release packet must leave the pressed flag set.
  a_release_sets_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.packet_done && res_r.packet_is_release |-> res_r.pressed_out)
    else $error("release packet finished without pressed flag");

  // The touch cell only moves when a byte is processed.
  a_cell_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !proc |=> $stable(cell_x_r) && $stable(cell_y_r))
    else $error("touch cell changed without a byte");

  // Back-pressure on the input only arises from a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a held result");

endmodule
